// File: src/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types, opcodes and constants of the small matrix multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

  // Default matrix dimensions
  localparam int ROWS_DEF  = 4;
  localparam int INNER_DEF = 4;
  localparam int COLS_DEF  = 4;

  // Transaction opcodes
  localparam logic [1:0] OP_LEFT  = 2'd0;
  localparam logic [1:0] OP_RIGHT = 2'd1;
  localparam logic [1:0] OP_MUL   = 2'd2;

  // Q16.16 element format
  localparam int ELEM_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * ELEM_W;

  // Clip values for out-of-range sums
  localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

  // Tag that travels with each operand pair into the MAC
  typedef struct packed {
    logic valid;  // operand pair present
    logic first;  // first term of a dot product
    logic last;   // final term of a dot product
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: src/smm_ram.sv
// ----------------------------------------------------------------------------
// smm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/smm_mac.sv
// ----------------------------------------------------------------------------
// smm_mac
// Two-stage multiply-accumulate for one dot product, with Q16.16 rescale and
// saturation of the finished sum.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_mac
  import smm_pkg::*;
#(
  parameter int INNER = INNER_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mac_ctl_t          ctl,
  input  wire logic [ELEM_W-1:0] a,
  input  wire logic [ELEM_W-1:0] b,
  output logic                   done,
  output logic      [ELEM_W-1:0] result,
  output logic                   sat
);

  // Room for INNER full products plus sign
  localparam int ACC_W = PROD_W + $clog2(INNER) + 1;
  localparam int TOP_LO = FRAC_W + ELEM_W - 1;

  mac_ctl_t                 pctl;
  logic signed [PROD_W-1:0] a_ext;
  logic signed [PROD_W-1:0] b_ext;
  logic [PROD_W-1:0]        prod;
  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         prod_ext;
  logic [ACC_W-TOP_LO-1:0]  top_bits;

  // Stage 1: signed 32x32 product
  always_ff @(posedge clk) begin
    if (rst) begin
      pctl <= '0;
    end else begin
      pctl <= ctl;
    end
  end

  // Sign-extended operands; the low 64 bits hold the full signed product
  assign a_ext = {{(PROD_W-ELEM_W){a[ELEM_W-1]}}, a};
  assign b_ext = {{(PROD_W-ELEM_W){b[ELEM_W-1]}}, b};

  always_ff @(posedge clk) begin
    prod <= a_ext * b_ext;
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  // Stage 2: accumulate, restart on first term
  always_ff @(posedge clk) begin
    if (pctl.valid) begin
      acc <= pctl.first ? prod_ext : acc + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pctl.valid & pctl.last;
    end
  end

  // Rescale and clip: sum fits when bit 47 and all bits above it match the sign
  assign top_bits = acc[ACC_W-1:TOP_LO];
  assign sat      = !((&top_bits) || !(|top_bits));
  assign result   = sat ? (acc[ACC_W-1] ? SAT_NEG : SAT_POS)
                        : acc[TOP_LO:FRAC_W];

endmodule

`default_nettype wire

// File: src/small_matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// small_matrix_multiply_unit
// Q16.16 matrix product of a ROWS x INNER left and an INNER x COLS right
// matrix held in two RAMs.
//
// Input channel (in_valid/in_stall): op 0 writes value at (row, col) of the
// left matrix, op 1 of the right matrix; out-of-range writes and op 3 are
// dropped. Writes are accepted back to back.
// Op 2 starts a product run; in_stall stays high until the last element of
// the run has been handed to the output register.
// Output channel (out_valid/out_stall): one transaction per product element,
// row-major, with last on the final one. Each element issues INNER reads
// through the single read port of each RAM into one shared MAC; the terms
// pass the RAM read, multiply and accumulate stages, and the output register
// loads before the first read of the next element is issued.
// While the output register holds an element and out_stall is high, the next
// element is not started, so the run simply pauses. Reset empties the output
// register and returns to idle; RAM contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module small_matrix_multiply_unit
  import smm_pkg::*;
#(
  parameter int ROWS  = ROWS_DEF,
  parameter int INNER = INNER_DEF,
  parameter int COLS  = COLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        op,
  input  wire logic [2:0]        row,
  input  wire logic [2:0]        col,
  input  wire logic [ELEM_W-1:0] value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [2:0]        out_row,
  output logic      [2:0]        out_col,
  output logic      [ELEM_W-1:0] product_value,
  output logic                   saturated,
  output logic                   last
);

  localparam int LDEPTH = ROWS * INNER;
  localparam int RDEPTH = INNER * COLS;
  localparam int LA_W   = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int RA_W   = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KW     = (INNER > 1) ? $clog2(INNER) : 1;
  localparam int CW     = (COLS > 1) ? $clog2(COLS) : 1;

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [RW-1:0]     r_idx;
  logic [CW-1:0]     c_idx;
  logic [KW-1:0]     k_idx;

  logic              in_acc;
  logic              l_we;
  logic              r_we;
  logic [6:0]        l_wa_full;
  logic [6:0]        r_wa_full;
  logic [6:0]        l_ra_full;
  logic [6:0]        r_ra_full;
  logic [ELEM_W-1:0] l_rdata;
  logic [ELEM_W-1:0] r_rdata;

  logic              issue;
  logic              k_last;
  logic              elem_last;
  mac_ctl_t          rd_ctl;
  mac_ctl_t          mac_ctl;

  logic              mac_done;
  logic [ELEM_W-1:0] mac_result;
  logic              mac_sat;

  // Input handshake and writes
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;

  assign l_we = in_acc && (op == OP_LEFT) && ({1'b0, row} < 4'(ROWS))
                && ({1'b0, col} < 4'(INNER));
  assign r_we = in_acc && (op == OP_RIGHT) && ({1'b0, row} < 4'(INNER))
                && ({1'b0, col} < 4'(COLS));

  assign l_wa_full = {4'b0, row} * 7'(INNER) + {4'b0, col};
  assign r_wa_full = {4'b0, row} * 7'(COLS) + {4'b0, col};

  // Read addresses for the current term
  assign l_ra_full = 7'(r_idx) * 7'(INNER) + 7'(k_idx);
  assign r_ra_full = 7'(k_idx) * 7'(COLS) + 7'(c_idx);

  smm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (LDEPTH)
  ) u_left_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_wa_full[LA_W-1:0]),
    .wdata (value),
    .raddr (l_ra_full[LA_W-1:0]),
    .rdata (l_rdata)
  );

  smm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (RDEPTH)
  ) u_right_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_wa_full[RA_W-1:0]),
    .wdata (value),
    .raddr (r_ra_full[RA_W-1:0]),
    .rdata (r_rdata)
  );

  // An element starts only once the output register will be free
  assign k_last    = (k_idx == KW'(INNER - 1));
  assign elem_last = (r_idx == RW'(ROWS - 1)) && (c_idx == CW'(COLS - 1));
  assign issue     = (state == ST_ISSUE)
                     && ((k_idx != '0) || !out_valid || !out_stall);

  assign rd_ctl.valid = issue;
  assign rd_ctl.first = (k_idx == '0);
  assign rd_ctl.last  = k_last;

  // Tag follows the registered RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_ctl <= '0;
    end else begin
      mac_ctl <= rd_ctl;
    end
  end

  smm_mac #(
    .INNER (INNER)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .a      (l_rdata),
    .b      (r_rdata),
    .done   (mac_done),
    .result (mac_result),
    .sat    (mac_sat)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (op == OP_MUL)) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (issue && k_last) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (mac_done) state_next = elem_last ? ST_IDLE : ST_ISSUE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      r_idx <= '0;
      c_idx <= '0;
      k_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        r_idx <= '0;
        c_idx <= '0;
        k_idx <= '0;
      end else if (issue) begin
        k_idx <= k_last ? '0 : k_idx + 1'b1;
      end else if ((state == ST_WAIT) && mac_done && !elem_last) begin
        if (c_idx == CW'(COLS - 1)) begin
          c_idx <= '0;
          r_idx <= r_idx + 1'b1;
        end else begin
          c_idx <= c_idx + 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mac_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_done) begin
      out_row       <= 3'(r_idx);
      out_col       <= 3'(c_idx);
      product_value <= mac_result;
      saturated     <= mac_sat;
      last          <= elem_last;
    end
  end

endmodule

`default_nettype wire
